[src/mts_pkg.sv]
// Shared types, constants and codes for the min-tracking stack.
package mts_pkg;

    // Sizes of the stack
    localparam int MTS_DEPTH      = 1024;
    localparam int MTS_VALUE_BITS = 32;
    localparam int MTS_ENTRY_BITS = MTS_VALUE_BITS + 2;
    localparam int MTS_FILL_BITS  = $clog2(MTS_DEPTH + 1);
    localparam int MTS_ADDR_BITS  = $clog2(MTS_DEPTH);

    // Request codes; any other code acts as a query
    localparam logic [1:0] MTS_REQ_PUSH  = 2'd0;
    localparam logic [1:0] MTS_REQ_POP   = 2'd1;
    localparam logic [1:0] MTS_REQ_QUERY = 2'd2;

    // Status codes
    localparam logic [1:0] MTS_ST_OK    = 2'd0;
    localparam logic [1:0] MTS_ST_EMPTY = 2'd1;
    localparam logic [1:0] MTS_ST_FULL  = 2'd2;

    // Request transaction
    typedef struct packed {
        logic [1:0]                       req_type;
        logic signed [MTS_VALUE_BITS-1:0] push_value;
    } t_in;

    // Result transaction
    typedef struct packed {
        logic signed [MTS_VALUE_BITS-1:0] item_value;
        logic signed [MTS_VALUE_BITS-1:0] min_value;
        logic [1:0]                       status;
        logic [MTS_FILL_BITS-1:0]         fill_level;
    } t_out;

    // Commands from the stack control to the entry RAM
    typedef struct packed {
        logic                      we;
        logic [MTS_ADDR_BITS-1:0]  waddr;
        logic [MTS_ENTRY_BITS-1:0] wdata;
        logic                      re;
        logic [MTS_ADDR_BITS-1:0]  raddr;
    } t_mem_cmd;

    // Control states
    typedef enum logic {
        S_IDLE,
        S_REFILL
    } t_state;

endpackage

[src/mts_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module mts_ram #(
    parameter int WIDTH     = 8,
    parameter int DEPTH     = 16,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/mts_stack_ctl.sv]
// Stack control: top entry and minimum registers, encode/decode, RAM commands.
module mts_stack_ctl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  mts_pkg::t_in                       i_req,
    output logic                               o_ready,
    output mts_pkg::t_out                      o_rsp,
    output mts_pkg::t_mem_cmd                  o_mem,
    input  logic [mts_pkg::MTS_ENTRY_BITS-1:0] i_mem_rdata
);

    import mts_pkg::*;

    localparam logic [MTS_FILL_BITS-1:0] FULL_LEVEL = MTS_FILL_BITS'(MTS_DEPTH);
    localparam logic [MTS_FILL_BITS-1:0] ONE_LEVEL  = MTS_FILL_BITS'(1);

    t_state                           r_state, n_state;
    logic [MTS_FILL_BITS-1:0]         r_ptr, n_ptr;
    logic signed [MTS_ENTRY_BITS-1:0] r_top, n_top;
    logic signed [MTS_VALUE_BITS-1:0] r_min, n_min;
    logic                             refill_load;

    logic                             empty, full, top_lt_min;
    logic signed [MTS_VALUE_BITS-1:0] push_x, top_dec;
    logic signed [MTS_ENTRY_BITS-1:0] x_ext, min_ext, enc_entry, restore_min;
    logic [MTS_FILL_BITS-1:0]         ptr_m1, ptr_m2, ptr_p1;
    logic                             pop_refill;

    // Status flags, decode and encode of the register-held top entry, pointer steps
    assign empty       = (r_ptr == '0);
    assign full        = (r_ptr == FULL_LEVEL);
    assign push_x      = i_req.push_value;
    assign x_ext       = MTS_ENTRY_BITS'(push_x);
    assign min_ext     = MTS_ENTRY_BITS'(r_min);
    assign top_lt_min  = (r_top < min_ext);
    assign top_dec     = top_lt_min ? r_min : r_top[MTS_VALUE_BITS-1:0];
    assign enc_entry   = (x_ext <<< 1) - min_ext;
    assign restore_min = (min_ext <<< 1) - r_top;
    assign ptr_m1      = r_ptr - ONE_LEVEL;
    assign ptr_m2      = r_ptr - MTS_FILL_BITS'(2);
    assign ptr_p1      = r_ptr + ONE_LEVEL;

    // Datapath: next register values, response and RAM commands
    always_comb begin
        n_ptr      = r_ptr;
        n_top      = r_top;
        n_min      = r_min;
        pop_refill = 1'b0;
        o_mem      = '0;
        o_mem.waddr = ptr_m1[MTS_ADDR_BITS-1:0];
        o_mem.wdata = r_top;
        o_mem.raddr = ptr_m2[MTS_ADDR_BITS-1:0];
        o_rsp.item_value = '0;
        o_rsp.min_value  = '0;
        o_rsp.status     = MTS_ST_EMPTY;
        o_rsp.fill_level = '0;
        case (i_req.req_type)
            MTS_REQ_PUSH: begin
                if (full) begin
                    o_rsp.item_value = top_dec;
                    o_rsp.min_value  = r_min;
                    o_rsp.status     = MTS_ST_FULL;
                    o_rsp.fill_level = r_ptr;
                end else begin
                    // Old top spills into the RAM, new value lives in the register
                    o_mem.we = i_accept && !empty;
                    n_ptr    = ptr_p1;
                    if (empty) begin
                        n_top = x_ext;
                        n_min = push_x;
                    end else if (push_x < r_min) begin
                        n_top = enc_entry;
                        n_min = push_x;
                    end else begin
                        n_top = x_ext;
                    end
                    o_rsp.item_value = push_x;
                    o_rsp.min_value  = n_min;
                    o_rsp.status     = MTS_ST_OK;
                    o_rsp.fill_level = ptr_p1;
                end
            end
            MTS_REQ_POP: begin
                if (!empty) begin
                    n_ptr = ptr_m1;
                    if (r_ptr == ONE_LEVEL) begin
                        n_min = '0;
                    end else begin
                        if (top_lt_min) begin
                            n_min = restore_min[MTS_VALUE_BITS-1:0];
                        end
                        // Next top entry comes back from the RAM
                        pop_refill = 1'b1;
                        o_mem.re   = i_accept;
                    end
                    o_rsp.item_value = top_dec;
                    o_rsp.min_value  = n_min;
                    o_rsp.status     = MTS_ST_OK;
                    o_rsp.fill_level = ptr_m1;
                end
            end
            default: begin
                if (!empty) begin
                    o_rsp.item_value = top_dec;
                    o_rsp.min_value  = r_min;
                    o_rsp.status     = MTS_ST_OK;
                    o_rsp.fill_level = r_ptr;
                end
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_accept && pop_refill) begin
                    n_state = S_REFILL;
                end
            end
            S_REFILL: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        o_ready     = 1'b0;
        refill_load = 1'b0;
        case (r_state)
            S_IDLE:   o_ready     = 1'b1;
            S_REFILL: refill_load = 1'b1;
            default:  o_ready     = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr   <= '0;
            r_min   <= '0;
        end else begin
            r_state <= n_state;
            if (i_accept) begin
                r_ptr <= n_ptr;
                r_min <= n_min;
            end
        end
    end

    // Top entry register
    always_ff @(posedge i_clk) begin
        if (refill_load) begin
            r_top <= i_mem_rdata;
        end else if (i_accept) begin
            r_top <= n_top;
        end
    end

    // Checks
    a_no_accept_in_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_REFILL |-> !i_accept)
        else $error("transaction accepted during top refill");

    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= FULL_LEVEL)
        else $error("stack pointer beyond depth");

    a_empty_min_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr == '0 |-> r_min == '0)
        else $error("minimum not cleared on empty stack");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_req.req_type == MTS_REQ_PUSH && !full
        |=> r_ptr == $past(ptr_p1))
        else $error("push did not advance the pointer");

    a_refill_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && pop_refill |=> r_state == S_REFILL)
        else $error("pop with entries left did not refill the top");

endmodule

[src/min_tracking_stack_core.sv]
// Top level of the min-tracking stack: handshakes, result register and entry RAM.
// A stack of signed 32-bit values that reports its minimum with every transaction,
// using one minimum register; pushes below the minimum are stored encoded in
// 34-bit entries. The top entry sits in a register and the entries below it in
// a 1024-entry RAM with one cycle of read latency. Push and query take one
// cycle each; a pop that leaves entries behind takes two cycles, since the new
// top entry must be read back from the RAM before the next request is taken.
// The result sits in an output register and is valid the cycle after its request
// is taken. A new request is taken in the same cycle that the waiting result is
// taken; a result left waiting holds off the next request. The RAM is never
// cleared: only written entries are read, and the block is ready right after reset.
module min_tracking_stack_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mts_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output mts_pkg::t_out o_out
);

    import mts_pkg::*;

    logic                      ctl_ready;
    logic                      in_accept;
    t_out                      rsp;
    t_mem_cmd                  mem_cmd;
    logic [MTS_ENTRY_BITS-1:0] mem_rdata;
    logic                      r_out_valid;
    t_out                      r_out;

    // Take a request when the control is idle and the result slot frees up
    assign o_in_ready = ctl_ready && (!r_out_valid || i_out_ready);
    assign in_accept  = i_in_valid && o_in_ready;

    mts_stack_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_req       (i_in),
        .o_ready     (ctl_ready),
        .o_rsp       (rsp),
        .o_mem       (mem_cmd),
        .i_mem_rdata (mem_rdata)
    );

    mts_ram #(
        .WIDTH (MTS_ENTRY_BITS),
        .DEPTH (MTS_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_cmd.we),
        .i_waddr (mem_cmd.waddr),
        .i_wdata (mem_cmd.wdata),
        .i_re    (mem_cmd.re),
        .i_raddr (mem_cmd.raddr),
        .o_rdata (mem_rdata)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[sim/min_tracking_stack_core_test.sv]
// Self-checking testbench for the min-tracking stack: directed, capacity, backpressure, random.
module min_tracking_stack_core_test;
    import mts_pkg::*;

    // Run limit in clock cycles
    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_ITEMS   = 50;
    localparam int FILL_POPS     = 40;

    // Request code the block treats as a query
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic signed [MTS_VALUE_BITS-1:0] VAL_MAX = {1'b0, {(MTS_VALUE_BITS-1){1'b1}}};
    localparam logic signed [MTS_VALUE_BITS-1:0] VAL_MIN = {1'b1, {(MTS_VALUE_BITS-1){1'b0}}};

    // Receiver stall patterns
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_MOSTLY,
        RX_PERIODIC
    } t_rx_mode;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    t_in  in_bus    = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_bus;

    // Shadow copy of the stack
    longint stack_mem [MTS_DEPTH];
    int     stack_fill = 0;
    longint stack_min  = 0;

    t_out   expected_results [$];
    t_out   want;
    int     mismatch_count = 0;
    int     cycle_count    = 0;

    // Sender burst control
    int     burst_left     = 0;
    bit     gaps_enabled   = 1'b1;

    // Receiver control
    int       hold_requests = 0;
    int       holds_served  = 0;
    int       hold_left     = 0;
    int       mode_left     = 0;
    t_rx_mode rx_mode       = RX_ALWAYS;

    min_tracking_stack_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_bus),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_bus)
    );

    always #5 clk = ~clk;

    // Run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Decoded top entry of the shadow stack
    function automatic longint top_value();
        longint t;
        t = stack_mem[stack_fill-1];
        return (t < stack_min) ? stack_min : t;
    endfunction

    // Apply one request to the shadow stack and queue the result it produces
    task automatic predict_stack_result(input t_in req);
        t_out   res;
        longint x;
        longint t;
        longint item;
        res  = '0;
        item = 0;
        x    = longint'(req.push_value);
        case (req.req_type)
            MTS_REQ_PUSH: begin
                if (stack_fill >= MTS_DEPTH) begin
                    res.status = MTS_ST_FULL;
                end else begin
                    if (stack_fill == 0) begin
                        stack_mem[0] = x;
                        stack_min    = x;
                    end else if (x < stack_min) begin
                        // encoded entry carries the previous minimum
                        stack_mem[stack_fill] = 2 * x - stack_min;
                        stack_min             = x;
                    end else begin
                        stack_mem[stack_fill] = x;
                    end
                    stack_fill++;
                    res.status = MTS_ST_OK;
                end
                item = top_value();
            end
            default: begin
                if (stack_fill == 0) begin
                    res.status = MTS_ST_EMPTY;
                end else if (req.req_type == MTS_REQ_POP) begin
                    t = stack_mem[stack_fill-1];
                    stack_fill--;
                    if (t < stack_min) begin
                        item      = stack_min;
                        stack_min = 2 * stack_min - t;
                    end else begin
                        item = t;
                    end
                    if (stack_fill == 0)
                        stack_min = 0;
                    res.status = MTS_ST_OK;
                end else begin
                    item       = top_value();
                    res.status = MTS_ST_OK;
                end
            end
        endcase
        res.item_value = item[MTS_VALUE_BITS-1:0];
        res.min_value  = (stack_fill == 0) ? '0 : stack_min[MTS_VALUE_BITS-1:0];
        res.fill_level = MTS_FILL_BITS'(stack_fill);
        expected_results.push_back(res);
    endtask

    // Offer one request, wait for its transaction, then idle per the burst pattern
    task automatic send_request(input logic [1:0] kind, input logic signed [31:0] value);
        t_in req;
        int  gap;
        req.req_type   = kind;
        req.push_value = value;
        in_bus   = req;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predict_stack_result(req);
        @(negedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = gaps_enabled ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
    endtask

    // Push value: extremes, small values, values around the minimum, or anything
    function automatic logic signed [31:0] pick_value();
        longint near;
        case ($urandom_range(0, 9))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return 32'(int'($urandom_range(0, 16)) - 8);
            3, 4: begin
                near = stack_min + longint'(int'($urandom_range(0, 6)) - 3);
                return near[31:0];
            end
            default: return $urandom;
        endcase
    endfunction

    // Result checker
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result: item %0d min %0d status %0d fill %0d",
                             out_bus.item_value, out_bus.min_value, out_bus.status,
                             out_bus.fill_level);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (out_bus.item_value !== want.item_value
                    || out_bus.min_value !== want.min_value
                    || out_bus.status !== want.status
                    || out_bus.fill_level !== want.fill_level)
                begin
                    if (mismatch_count < 10)
                        $display({"mismatch: exp item %0d min %0d status %0d fill %0d",
                                  " / got item %0d min %0d status %0d fill %0d"},
                                 want.item_value, want.min_value, want.status, want.fill_level,
                                 out_bus.item_value, out_bus.min_value, out_bus.status,
                                 out_bus.fill_level);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver: long hold-offs on request, otherwise a changing stall pattern
    always @(negedge clk) begin
        if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready = 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_ALWAYS: out_ready = 1'b1;
                RX_COIN:   out_ready = 1'($urandom_range(0, 1));
                RX_MOSTLY: out_ready = ($urandom_range(0, 99) < 85);
                default:   out_ready = (mode_left % 5) != 0;
            endcase
        end
    end

    // Empty-stack cases, extremes, encoded and plain entries, unused code
    task automatic test_empty_and_extremes();
        send_request(MTS_REQ_POP, 32'sd0);
        send_request(MTS_REQ_QUERY, 32'sd0);
        send_request(REQ_UNUSED, VAL_MAX);
        send_request(MTS_REQ_PUSH, VAL_MAX);
        send_request(MTS_REQ_PUSH, VAL_MAX);
        send_request(MTS_REQ_PUSH, VAL_MIN);
        send_request(MTS_REQ_QUERY, 32'sd0);
        send_request(MTS_REQ_PUSH, VAL_MIN);
        send_request(MTS_REQ_PUSH, VAL_MAX);
        send_request(MTS_REQ_PUSH, -32'sd5);
        send_request(REQ_UNUSED, 32'sd0);
        send_request(MTS_REQ_POP, 32'sd0);
        send_request(MTS_REQ_POP, 32'sd0);
        send_request(MTS_REQ_POP, 32'sd0);
        send_request(MTS_REQ_POP, 32'sd0);
        send_request(MTS_REQ_QUERY, 32'sd0);
        send_request(MTS_REQ_POP, 32'sd0);
        send_request(MTS_REQ_POP, 32'sd0);
        send_request(MTS_REQ_POP, 32'sd0);
        send_request(MTS_REQ_PUSH, 32'sd0);
        send_request(MTS_REQ_PUSH, -32'sd1);
        send_request(MTS_REQ_PUSH, 32'sd1);
        send_request(MTS_REQ_POP, 32'sd0);
        send_request(MTS_REQ_POP, 32'sd0);
        send_request(MTS_REQ_POP, 32'sd0);
    endtask

    // Fill to capacity, push into a full stack, then pop part of it back
    task automatic test_fill_to_capacity();
        gaps_enabled = 1'b0;
        for (int i = 0; i < MTS_DEPTH; i++)
            send_request(MTS_REQ_PUSH, pick_value());
        gaps_enabled = 1'b1;
        for (int i = 0; i < 3; i++)
            send_request(MTS_REQ_PUSH, pick_value());
        send_request(MTS_REQ_QUERY, 32'sd0);
        for (int i = 0; i < FILL_POPS; i++)
            send_request(MTS_REQ_POP, 32'sd0);
    endtask

    // Receiver holds off while requests keep coming, so the block stalls its input
    task automatic test_output_backpressure();
        gaps_enabled = 1'b0;
        hold_requests++;
        for (int i = 0; i < 40; i++)
            send_request((i % 4 == 3) ? MTS_REQ_POP : MTS_REQ_PUSH, pick_value());
        for (int i = 0; i < 30; i++)
            send_request(MTS_REQ_POP, 32'sd0);
        gaps_enabled = 1'b1;
    endtask

    // Random traffic in phases with different push/pop balance
    task automatic test_random_traffic();
        int push_pct;
        int r;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 3))
                0:       push_pct = 20;
                1:       push_pct = 50;
                2:       push_pct = 80;
                default: push_pct = 95;
            endcase
            gaps_enabled = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                r = $urandom_range(0, 99);
                if (r < push_pct)
                    send_request(MTS_REQ_PUSH, pick_value());
                else if (r < push_pct + (3 * (100 - push_pct)) / 4)
                    send_request(MTS_REQ_POP, $urandom);
                else
                    send_request($urandom_range(0, 1) ? MTS_REQ_QUERY : REQ_UNUSED, $urandom);
            end
        end
        gaps_enabled = 1'b1;
    endtask

    // Main sequence
    initial begin
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_empty_and_extremes();
        test_fill_to_capacity();
        test_output_backpressure();
        test_random_traffic();
        in_valid = 1'b0;
        wait (expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
